[rtl/frsm_pkg.sv]
// frsm_pkg: shared codes and fixed widths for the flash record slot manager
// used by flash_record_slot_manager_top and its testbench
package frsm_pkg;

    localparam int RECW = 13;
    localparam int REQW = 12;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_LOCATE  = 2'd1;
    localparam logic [1:0] OP_COMMIT  = 2'd2;
    localparam logic [1:0] OP_RESTORE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_COPY  = 2'd2;

    localparam logic CFG_REQ_BYTES   = 1'b0;
    localparam logic CFG_ERASED_ONES = 1'b1;

endpackage

[rtl/frsm_ram.sv]
// frsm_ram: generic single-write, single-read ram with registered read
// no dependencies
module frsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/frsm_div.sv]
// frsm_div: restoring divider, one quotient bit per cycle
// depends on nothing; shared by all divisions of the slot manager
module frsm_div #(
    parameter int DW = 18
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] dvs_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;

    assign shifted  = {rem_reg, quo_reg[DW-1]};
    assign trial    = shifted - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (!trial[DW]) begin
                    rem_reg <= trial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

[rtl/flash_record_slot_manager_top.sv]
// flash_record_slot_manager_top: slot bookkeeping for record copies in one erase sector
// depends on frsm_pkg, frsm_div (shared divider) and frsm_ram (slot bitmap)
// every op ends with percent used, which needs up to three divisions on the shared divider;
// locate adds a division and reads the bitmap one word at a time, commit adds a division and
// on erase writes the bitmap words one at a time, restore adds a division when a bit is put back
// DW = clog2(SECTOR_BYTES)+6; next transfer accepted the cycle after the result is loaded
// one transfer in flight at a time; synchronous active-low reset clears control state
module flash_record_slot_manager_top #(
    parameter int SECTOR_BYTES = 4096,
    parameter int MIN_RECORD   = 16,
    parameter int MAP_WORDS    = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // size_matches, word_index[4:0], word_data[31:0], force_erase
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // current_offset[12:0], erase_sector, bitmap_word_index[4:0],
                                   // bitmap_word[31:0], percent_used[7:0]
    output logic [1:0]  m_tuser    // status
);
    localparam int RECW = frsm_pkg::RECW;
    localparam int OFFW = $clog2(SECTOR_BYTES + 1);
    localparam int DW   = $clog2(SECTOR_BYTES) + 6;
    localparam int AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int MAPW = $clog2(4 * MAP_WORDS + 1);
    localparam int NW   = MAPW + 3;
    localparam int PW   = NW + RECW;
    localparam int XW   = PW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_LOC_GO, S_LOC_WAIT, S_LOC_MAP, S_SCAN_RD, S_SCAN_CHK, S_SCAN_MUL,
        S_SCAN_FIN, S_CMT, S_ERASE, S_IDX_GO, S_IDX_WAIT, S_RD0, S_RDW, S_WR,
        S_PCT, S_PCT_SL_WAIT, S_PCT_IX_GO, S_PCT_IX_WAIT, S_PCT_P_GO, S_PCT_P_WAIT, S_OUT
    } state_t;

    state_t state_reg;

    logic [11:0]     req_reg;
    logic            ones_reg;
    logic [1:0]      op_reg;
    logic            match_reg;
    logic            force_reg;
    logic [RECW-1:0] sz_reg;
    logic [OFFW-1:0] newest_reg;
    logic [OFFW-1:0] prior_reg;
    logic [MAPW-1:0] map_reg;
    logic [RECW-1:0] rec_reg;
    logic [AW-1:0]   scan_w_reg;
    logic            erased_reg;
    logic [NW-1:0]   n_reg;
    logic [PW-1:0]   prod_reg;
    logic [DW-1:0]   slot_reg;
    logic            b0_reg;
    logic [DW-1:0]   slots_reg;
    logic [DW-1:0]   idx_reg;
    logic [1:0]      status_reg;
    logic            erase_reg;
    logic [4:0]      widx_reg;
    logic [31:0]     wval_reg;
    logic [7:0]      pct_reg;
    logic            m_tvalid_reg;
    logic [63:0]     m_tdata_reg;
    logic [1:0]      m_tuser_reg;

    logic            in_match;
    logic [4:0]      in_widx;
    logic [31:0]     in_wdata;
    logic            in_force;
    logic            accept;

    assign in_match = s_tdata[0];
    assign in_widx  = s_tdata[5:1];
    assign in_wdata = s_tdata[37:6];
    assign in_force = s_tdata[38];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // record size clamp and alignment
    logic            req_bad;
    logic [RECW-1:0] req_min;
    logic [RECW-1:0] sz_c;
    assign req_bad = (req_reg == '0) ||
                     ((OFFW+2)'(req_reg) > (OFFW+2)'(SECTOR_BYTES - 8));
    assign req_min = ((RECW)'(req_reg) < RECW'(MIN_RECORD)) ? RECW'(MIN_RECORD)
                                                            : RECW'(req_reg);
    assign sz_c    = (req_min + RECW'(3)) & ~RECW'(3);

    // slot index operand
    logic [OFFW:0]   base_off;
    logic [DW-1:0]   diff_off;
    assign base_off = (OFFW+1)'(4) + (OFFW+1)'(map_reg);
    assign diff_off = ({1'b0, newest_reg} >= base_off)
                    ? DW'({1'b0, newest_reg} - base_off) : '0;

    // shared divider
    logic          div_start;
    logic [DW-1:0] div_a;
    logic [DW-1:0] div_b;
    logic          div_done;
    logic [DW-1:0] div_q;
    logic [DW-1:0] div_q1;
    logic [DW+6:0] idx_x100;
    assign div_q1   = div_q + DW'(1);
    assign idx_x100 = (DW+7)'(idx_reg) * (DW+7)'(100);

    always_comb begin
        div_start = 1'b0;
        div_a     = diff_off;
        div_b     = DW'(rec_reg);
        unique case (state_reg)
            S_LOC_GO: begin
                div_start = 1'b1;
                div_a     = DW'((SECTOR_BYTES - 4) * 8 - 1);
                div_b     = DW'({sz_reg, 3'b000}) + DW'(1);
            end
            S_IDX_GO, S_PCT_IX_GO: begin
                div_start = 1'b1;
            end
            S_PCT: begin
                div_start = (newest_reg != '0) && (rec_reg != '0);
                div_a     = DW'(SECTOR_BYTES - 4) - DW'(map_reg);
            end
            S_PCT_P_GO: begin
                div_start = 1'b1;
                div_a     = idx_x100[DW-1:0];
                div_b     = slots_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    frsm_div #(.DW(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // bitmap sizing from the copy count
    logic [DW-1:0]   bm_raw;
    logic [MAPW-1:0] bm;
    assign bm_raw = ((div_q + DW'(32)) >> 3) & ~DW'(3) & DW'(16'h7fff);
    assign bm     = (bm_raw > DW'(4 * MAP_WORDS)) ? MAPW'(4 * MAP_WORDS) : MAPW'(bm_raw);

    // slot bitmap memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [AW-1:0] last_w;
    logic [DW-1:0] slot_w;
    logic [31:0]   slot_mask;
    logic [31:0]   wr_word;
    logic          load_ok;

    assign last_w    = AW'(map_reg[MAPW-1:2]) - AW'(1);
    assign slot_w    = slot_reg >> 5;
    assign slot_mask = 32'd1 << slot_reg[4:0];
    assign load_ok   = (7'(in_widx) < 7'(MAP_WORDS));

    always_comb begin
        if (op_reg == frsm_pkg::OP_COMMIT) begin
            wr_word = b0_reg ? (ram_rdata & ~slot_mask) : (ram_rdata | slot_mask);
        end else begin
            wr_word = b0_reg ? (ram_rdata | slot_mask) : (ram_rdata & ~slot_mask);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = scan_w_reg;
        ram_wdata = ones_reg ? 32'hffff_ffff : 32'h0;
        ram_raddr = scan_w_reg;
        unique case (state_reg)
            S_IDLE: begin
                ram_we    = accept && (s_tuser == frsm_pkg::OP_LOAD) && load_ok;
                ram_waddr = AW'(7'(in_widx));
                ram_wdata = in_wdata;
            end
            S_ERASE: begin
                ram_we = 1'b1;
            end
            S_RD0: begin
                ram_raddr = '0;
            end
            S_RDW: begin
                ram_raddr = AW'(slot_w);
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(slot_w);
                ram_wdata = wr_word;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    frsm_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // first erased bit in the fetched bitmap word
    logic          erased_now;
    logic          hit_found;
    logic [4:0]    hit_bit;
    always_comb begin
        erased_now = (scan_w_reg == '0) ? ram_rdata[0] : erased_reg;
        hit_found  = 1'b0;
        hit_bit    = '0;
        for (int b = 31; b >= 0; b--) begin
            if ((ram_rdata[b] == erased_now) && !((scan_w_reg == '0) && (b < 2))) begin
                hit_found = 1'b1;
                hit_bit   = 5'(b);
            end
        end
    end

    logic [XW-1:0] scan_off;
    logic [XW-1:0] scan_end;
    assign scan_off = XW'(4) + XW'(map_reg) + XW'(prod_reg);
    assign scan_end = scan_off + XW'(rec_reg);

    logic [OFFW+1:0] cmt_end;
    assign cmt_end = (OFFW+2)'(newest_reg) + (OFFW+2)'({rec_reg, 1'b0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            req_reg      <= 12'd16;
            ones_reg     <= 1'b1;
            newest_reg   <= '0;
            prior_reg    <= '0;
            map_reg      <= '0;
            rec_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    frsm_pkg::CFG_REQ_BYTES:   req_reg  <= cfg_wdata;
                    frsm_pkg::CFG_ERASED_ONES: ones_reg <= cfg_wdata[0];
                    default:                   req_reg  <= req_reg;
                endcase
            end
            if ((state_reg == S_OUT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg     <= s_tuser;
                        match_reg  <= in_match;
                        force_reg  <= in_force;
                        status_reg <= frsm_pkg::ST_OK;
                        erase_reg  <= 1'b0;
                        widx_reg   <= '0;
                        wval_reg   <= '0;
                        unique case (s_tuser)
                            frsm_pkg::OP_LOAD: state_reg <= S_PCT;
                            frsm_pkg::OP_LOCATE: begin
                                if (req_bad) begin
                                    status_reg <= frsm_pkg::ST_BAD_SIZE;
                                    state_reg  <= S_PCT;
                                end else begin
                                    sz_reg    <= sz_c;
                                    state_reg <= S_LOC_GO;
                                end
                            end
                            frsm_pkg::OP_COMMIT: state_reg <= S_CMT;
                            default: begin
                                if ((newest_reg != prior_reg) && (newest_reg != '0) &&
                                    (rec_reg != '0)) begin
                                    state_reg <= S_IDX_GO;
                                end else begin
                                    newest_reg <= prior_reg;
                                    state_reg  <= S_PCT;
                                end
                            end
                        endcase
                    end
                end
                S_LOC_GO: state_reg <= S_LOC_WAIT;
                S_LOC_WAIT: begin
                    if (div_done) begin
                        map_reg   <= bm;
                        rec_reg   <= sz_reg;
                        state_reg <= S_LOC_MAP;
                    end
                end
                S_LOC_MAP: begin
                    if (!match_reg || (map_reg == '0)) begin
                        newest_reg <= '0;
                        status_reg <= frsm_pkg::ST_NO_COPY;
                        state_reg  <= S_PCT;
                    end else begin
                        scan_w_reg <= '0;
                        state_reg  <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    erased_reg <= erased_now;
                    if ((scan_w_reg == '0) && (ram_rdata[1] == ram_rdata[0])) begin
                        newest_reg <= '0;
                        status_reg <= frsm_pkg::ST_NO_COPY;
                        state_reg  <= S_PCT;
                    end else if (hit_found) begin
                        n_reg     <= NW'({scan_w_reg, hit_bit});
                        state_reg <= S_SCAN_MUL;
                    end else if (scan_w_reg == last_w) begin
                        n_reg     <= NW'({map_reg, 3'b000});
                        state_reg <= S_SCAN_MUL;
                    end else begin
                        scan_w_reg <= scan_w_reg + AW'(1);
                        state_reg  <= S_SCAN_RD;
                    end
                end
                S_SCAN_MUL: begin
                    prod_reg  <= PW'(n_reg - NW'(2)) * PW'(rec_reg);
                    state_reg <= S_SCAN_FIN;
                end
                S_SCAN_FIN: begin
                    if (scan_end > XW'(SECTOR_BYTES)) begin
                        newest_reg <= '0;
                        status_reg <= frsm_pkg::ST_NO_COPY;
                    end else begin
                        newest_reg <= OFFW'(scan_off);
                    end
                    state_reg <= S_PCT;
                end
                S_CMT: begin
                    if ((rec_reg == '0) || (map_reg == '0)) begin
                        status_reg <= frsm_pkg::ST_BAD_SIZE;
                        state_reg  <= S_PCT;
                    end else begin
                        prior_reg <= newest_reg;
                        if (force_reg || (newest_reg == '0) ||
                            (cmt_end > (OFFW+2)'(SECTOR_BYTES))) begin
                            erase_reg  <= 1'b1;
                            newest_reg <= OFFW'(base_off);
                            scan_w_reg <= '0;
                            state_reg  <= S_ERASE;
                        end else begin
                            newest_reg <= newest_reg + OFFW'(rec_reg);
                            state_reg  <= S_IDX_GO;
                        end
                    end
                end
                S_ERASE: begin
                    if (scan_w_reg == last_w) begin
                        state_reg <= S_IDX_GO;
                    end else begin
                        scan_w_reg <= scan_w_reg + AW'(1);
                    end
                end
                S_IDX_GO: state_reg <= S_IDX_WAIT;
                S_IDX_WAIT: begin
                    if (div_done) begin
                        slot_reg <= div_q1;
                        if ((div_q1 >> 5) < DW'(MAP_WORDS)) begin
                            state_reg <= S_RD0;
                        end else begin
                            if (op_reg == frsm_pkg::OP_RESTORE) begin
                                newest_reg <= prior_reg;
                            end
                            state_reg <= S_PCT;
                        end
                    end
                end
                S_RD0: state_reg <= S_RDW;
                S_RDW: begin
                    b0_reg    <= ram_rdata[0];
                    state_reg <= S_WR;
                end
                S_WR: begin
                    if (op_reg == frsm_pkg::OP_COMMIT) begin
                        widx_reg <= slot_w[4:0];
                        wval_reg <= wr_word;
                    end else begin
                        newest_reg <= prior_reg;
                    end
                    state_reg <= S_PCT;
                end
                S_PCT: begin
                    if ((newest_reg == '0) || (rec_reg == '0)) begin
                        pct_reg   <= 8'hff;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_PCT_SL_WAIT;
                    end
                end
                S_PCT_SL_WAIT: begin
                    if (div_done) begin
                        slots_reg <= div_q;
                        if (div_q == '0) begin
                            pct_reg   <= 8'd100;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_PCT_IX_GO;
                        end
                    end
                end
                S_PCT_IX_GO: state_reg <= S_PCT_IX_WAIT;
                S_PCT_IX_WAIT: begin
                    if (div_done) begin
                        idx_reg   <= div_q1;
                        state_reg <= S_PCT_P_GO;
                    end
                end
                S_PCT_P_GO: state_reg <= S_PCT_P_WAIT;
                S_PCT_P_WAIT: begin
                    if (div_done) begin
                        pct_reg   <= (div_q > DW'(100)) ? 8'd100 : div_q[7:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {5'b0, pct_reg, wval_reg, widx_reg, erase_reg,
                                         13'(newest_reg)};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[tb/flash_record_slot_manager_top_tb.sv]
// testbench for flash_record_slot_manager_top: directed table, then random slot traffic
// self-checking against an in-bench predictor of the slot bookkeeping; needs frsm_pkg
`timescale 1ns / 1ps

module flash_record_slot_manager_top_tb;
    import frsm_pkg::*;

    localparam int SECTOR = 4096;
    localparam int MINREC = 16;
    localparam int NWORDS = 32;
    localparam int N_ITEMS = 1750;
    localparam int QUIET_AT = 1550;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  st;
        logic [12:0] off;
        logic        er;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic [7:0]  pct;
    } slot_result_t;

    typedef struct {
        bit          is_cfg;
        logic        addr;
        logic [11:0] val;
        logic [1:0]  op;
        bit          sm;
        logic [4:0]  idx;
        logic [31:0] data;
        bit          fe;
        bit          typed;
        logic [1:0]  st;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // size_matches, word_index[4:0], word_data[31:0], force_erase
    logic [1:0]  s_tuser = '0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // current_offset[12:0], erase_sector, bitmap_word_index[4:0],
                                 // bitmap_word[31:0], percent_used[7:0]
    logic [1:0]  m_tuser;        // status

    flash_record_slot_manager_top dut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    int unsigned req_bytes = 16;
    int unsigned erased_ones = 1;
    logic [31:0] slot_map [NWORDS];
    int unsigned newest_off = 0, prior_off = 0, map_bytes = 0, rec_bytes = 0;

    slot_result_t slot_results_q[$];
    int  mismatches = 0;
    int  sent_items = 0;
    int  got_results = 0;
    int  commits = 0, erases = 0;
    longint cycles = 0;
    bit  quiet = 0;
    int  rx_stall = 0;

    function automatic int unsigned map_bit(int unsigned n);
        if ((n >> 5) >= NWORDS) return 0;
        return slot_map[n >> 5][n & 31];
    endfunction

    function automatic int unsigned slot_number();
        int unsigned base = 4 + map_bytes;
        int unsigned diff = newest_off >= base ? newest_off - base : 0;
        return 1 + diff / rec_bytes;
    endfunction

    function automatic int used_percent();
        int unsigned slots, p;
        if (newest_off == 0 || rec_bytes == 0) return -1;
        slots = (SECTOR - 4 - map_bytes) / rec_bytes;
        if (slots == 0) return 100;
        p = (100 * slot_number()) / slots;
        return p > 100 ? 100 : int'(p);
    endfunction

    function automatic int unsigned find_newest();
        int unsigned erased = slot_map[0][0];
        int unsigned off = 4 + map_bytes;
        if (slot_map[0][1] == erased) return 0;
        for (int unsigned n = 2; n < 8 * map_bytes; n++) begin
            if (map_bit(n) == erased) return off;
            off += rec_bytes;
        end
        return off;
    endfunction

    function automatic slot_result_t predict_slot_result(logic [1:0] op, bit sm,
            logic [4:0] idx, logic [31:0] data, bit fe);
        slot_result_t r;
        int unsigned sz, copies, bm, off, n, w;
        logic [31:0] mask;
        int pc;
        r = '0;
        r.st = ST_OK;
        case (op)
            OP_LOAD: begin
                slot_map[idx] = data;
            end
            OP_LOCATE: begin
                sz = req_bytes;
                if (sz == 0 || sz > SECTOR - 8) begin
                    r.st = ST_BAD_SIZE;
                end else begin
                    if (sz < MINREC) sz = MINREC;
                    sz = (sz + 3) & ~32'd3;
                    copies = ((SECTOR - 4) * 8 - 1) / (sz * 8 + 1);
                    bm = (((copies + 1) + 31) / 8) & ~32'd3;
                    bm &= 32'h7fff;
                    if (bm > 4 * NWORDS) bm = 4 * NWORDS;
                    map_bytes = bm;
                    rec_bytes = sz;
                    if (!sm || map_bytes == 0) begin
                        newest_off = 0;
                    end else begin
                        off = find_newest();
                        if (off == 0 || off + rec_bytes > SECTOR) off = 0;
                        newest_off = off;
                    end
                    if (newest_off == 0) r.st = ST_NO_COPY;
                end
            end
            OP_COMMIT: begin
                if (rec_bytes == 0 || map_bytes == 0) begin
                    r.st = ST_BAD_SIZE;
                end else begin
                    prior_off = newest_off;
                    if (fe || newest_off == 0 || newest_off + 2 * rec_bytes > SECTOR) begin
                        for (w = 0; w < map_bytes / 4 && w < NWORDS; w++)
                            slot_map[w] = erased_ones ? 32'hffff_ffff : 32'h0;
                        newest_off = 4 + map_bytes;
                        r.er = 1'b1;
                    end else begin
                        newest_off += rec_bytes;
                    end
                    n = slot_number();
                    w = n >> 5;
                    if (w < NWORDS) begin
                        mask = 32'd1 << (n & 31);
                        if (slot_map[0][0]) slot_map[w] &= ~mask;
                        else slot_map[w] |= mask;
                        r.widx = w[4:0];
                        r.wval = slot_map[w];
                    end
                end
            end
            default: begin
                if (newest_off != prior_off && newest_off != 0 && rec_bytes != 0) begin
                    n = slot_number();
                    w = n >> 5;
                    if (w < NWORDS) begin
                        mask = 32'd1 << (n & 31);
                        if (slot_map[0][0]) slot_map[w] |= mask;
                        else slot_map[w] &= ~mask;
                    end
                end
                newest_off = prior_off;
            end
        endcase
        r.off = newest_off[12:0];
        pc = used_percent();
        r.pct = pc[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", got_results, what, got, want);
    endtask

    task automatic send_slot_op(logic [1:0] op, bit sm, logic [4:0] idx, logic [31:0] data,
            bit fe, bit typed = 0, logic [1:0] st = ST_OK);
        slot_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, fe, data, idx, sm};
        do @(posedge aclk); while (!s_tready);
        r = predict_slot_result(op, sm, idx, data, fe);
        if (typed) r.st = st;
        if (op == OP_COMMIT && r.st == ST_OK) begin
            commits++;
            if (r.er) erases++;
        end
        slot_results_q.push_back(r);
        sent_items++;
        if (sent_items >= QUIET_AT) quiet = 1;
        if (!quiet && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (slot_results_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_cfg(logic addr, logic [11:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_REQ_BYTES) req_bytes = val;
        else erased_ones = val[0];
    endtask

    // writes all map words: bits 1..used flipped from the erased value, some words noise
    task automatic load_slot_map(int used, bit e, bit noisy);
        logic [31:0] word;
        for (int w = 0; w < NWORDS; w++) begin
            word = e ? 32'hffff_ffff : 32'h0;
            for (int b = 0; b < 32; b++)
                if (w * 32 + b >= 1 && w * 32 + b <= used) word[b] = ~e;
            if (noisy && $urandom_range(7) == 0) word = $urandom;
            send_slot_op(OP_LOAD, 0, w[4:0], word, 0);
        end
    endtask

    // result side
    always @(posedge aclk) begin
        slot_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[12:0], m_tdata[13], m_tdata[18:14], m_tdata[50:19],
                   m_tdata[58:51]};
            if (slot_results_q.size() == 0) begin
                report_mismatch("unexpected transfer", got, 0);
            end else begin
                want = slot_results_q.pop_front();
                if (got.st != want.st) report_mismatch("status", got.st, want.st);
                if (got.off != want.off) report_mismatch("current_offset", got.off, want.off);
                if (got.er != want.er) report_mismatch("erase_sector", got.er, want.er);
                if (got.widx != want.widx)
                    report_mismatch("bitmap_word_index", got.widx, want.widx);
                if (got.wval != want.wval) report_mismatch("bitmap_word", got.wval, want.wval);
                if (got.pct != want.pct) report_mismatch("percent_used", got.pct, want.pct);
            end
            got_results++;
        end
        if (rx_stall == 0 && !quiet && $urandom_range(4) == 0)
            rx_stall = $urandom_range(1, 11);
        else if (rx_stall > 0)
            rx_stall--;
        m_tready <= aresetn && (rx_stall == 0);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic dir_row_t op_row(logic [1:0] op, bit sm, logic [4:0] idx,
            logic [31:0] data, bit fe, bit typed = 0, logic [1:0] st = ST_OK);
        dir_row_t d;
        d = '{default: '0};
        d.op = op; d.sm = sm; d.idx = idx; d.data = data; d.fe = fe;
        d.typed = typed; d.st = st;
        return d;
    endfunction

    function automatic dir_row_t cfg_row(logic addr, logic [11:0] val);
        dir_row_t d;
        d = '{default: '0};
        d.is_cfg = 1; d.addr = addr; d.val = val;
        return d;
    endfunction

    initial begin
        dir_row_t rows[$];
        int unsigned pick;
        logic [11:0] rq;
        rows.push_back(op_row(OP_COMMIT, 0, 0, 0, 0, 1, ST_BAD_SIZE));
        rows.push_back(op_row(OP_RESTORE, 0, 0, 0, 0, 1, ST_OK));
        rows.push_back(op_row(OP_LOCATE, 0, 0, 0, 0, 1, ST_NO_COPY));
        rows.push_back(op_row(OP_LOAD, 0, 0, 32'hffff_ffff, 0));
        rows.push_back(op_row(OP_LOCATE, 1, 0, 0, 0, 1, ST_NO_COPY));
        rows.push_back(op_row(OP_COMMIT, 0, 0, 0, 0));
        rows.push_back(op_row(OP_COMMIT, 0, 0, 0, 0));
        rows.push_back(op_row(OP_COMMIT, 0, 0, 0, 1));
        rows.push_back(op_row(OP_RESTORE, 0, 0, 0, 0));
        rows.push_back(op_row(OP_RESTORE, 0, 0, 0, 0));
        rows.push_back(op_row(OP_LOAD, 0, 0, 32'hffff_fff9, 0));
        rows.push_back(op_row(OP_LOCATE, 1, 0, 0, 0, 1, ST_OK));
        rows.push_back(op_row(OP_LOAD, 0, 31, 32'h0, 0));
        rows.push_back(cfg_row(CFG_REQ_BYTES, 12'd0));
        rows.push_back(op_row(OP_LOCATE, 1, 0, 0, 0, 1, ST_BAD_SIZE));
        rows.push_back(cfg_row(CFG_REQ_BYTES, 12'd4089));
        rows.push_back(op_row(OP_LOCATE, 1, 0, 0, 0, 1, ST_BAD_SIZE));
        rows.push_back(cfg_row(CFG_REQ_BYTES, 12'd4088));
        rows.push_back(op_row(OP_LOCATE, 1, 0, 0, 0));
        rows.push_back(op_row(OP_COMMIT, 0, 0, 0, 0));
        rows.push_back(op_row(OP_COMMIT, 0, 0, 0, 0));
        rows.push_back(cfg_row(CFG_ERASED_ONES, 12'd0));
        rows.push_back(cfg_row(CFG_REQ_BYTES, 12'd1));
        rows.push_back(op_row(OP_LOAD, 0, 0, 32'h0000_0006, 0));
        rows.push_back(op_row(OP_LOCATE, 1, 0, 0, 0, 1, ST_OK));
        rows.push_back(op_row(OP_COMMIT, 0, 0, 0, 0));
        rows.push_back(op_row(OP_RESTORE, 0, 0, 0, 0));

        for (int w = 0; w < NWORDS; w++) slot_map[w] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every map word gets written before anything reads it
        load_slot_map(0, 1, 0);
        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_idle();
                write_cfg(rows[i].addr, rows[i].val);
            end else begin
                send_slot_op(rows[i].op, rows[i].sm, rows[i].idx, rows[i].data, rows[i].fe,
                             rows[i].typed, rows[i].st);
            end
        end

        while (sent_items < N_ITEMS) begin
            if ($urandom_range(2) == 0) begin
                wait_idle();
                pick = $urandom_range(9);
                case (pick)
                    0: rq = 12'd0;
                    1: rq = 12'd4095;
                    2: rq = 12'd4088;
                    3: rq = 12'd16;
                    4, 5: rq = 12'($urandom_range(1, 4095));
                    default: rq = 12'($urandom_range(1, 200));
                endcase
                write_cfg(CFG_REQ_BYTES, rq);
                write_cfg(CFG_ERASED_ONES, 12'($urandom_range(1)));
            end
            load_slot_map(int'($urandom_range(0, 300)),
                          ($urandom_range(7) == 0) ? !erased_ones[0] : erased_ones[0],
                          $urandom_range(3) == 0);
            send_slot_op(OP_LOCATE, $urandom_range(9) != 0, 5'($urandom), $urandom,
                         1'($urandom));
            repeat ($urandom_range(10, 60)) begin
                pick = $urandom_range(19);
                if (pick < 14)
                    send_slot_op(OP_COMMIT, 1'($urandom), 5'($urandom), $urandom,
                                 $urandom_range(9) == 0);
                else if (pick < 16)
                    send_slot_op(OP_RESTORE, 1'($urandom), 5'($urandom), $urandom,
                                 1'($urandom));
                else if (pick < 18)
                    send_slot_op(OP_LOAD, 1'($urandom), 5'($urandom), $urandom,
                                 1'($urandom));
                else
                    send_slot_op(OP_LOCATE, 1'($urandom), 5'($urandom), $urandom,
                                 1'($urandom));
            end
        end

        s_tvalid <= 1'b0;
        while (slot_results_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("ran %0d transfers in, %0d results checked", sent_items, got_results);
        $display("%0d commits, %0d of them with sector erase", commits, erases);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
